>>> design/bmp24sd_pkg.sv
// ----------------------------------------------------------------------------
// bmp24sd_pkg
// Types and constants shared by the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmp24sd_pkg;

	// Header constants
	localparam logic [15:0] SIGNATURE     = 16'h4D42;
	localparam logic [31:0] INFO_SIZE     = 32'd40;
	localparam logic [15:0] PLANES        = 16'd1;
	localparam logic [15:0] BIT_COUNT     = 16'd24;
	localparam logic [31:0] HEADER_BYTES  = 32'd54;
	localparam logic [31:0] LAST_HDR_POS  = 32'd53;
	localparam logic [31:0] MAX_WIDTH     = 32'd4096;
	localparam logic [31:0] MAX_HEIGHT    = 32'd4096;

	// Result queue geometry
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_TRUNC_HEADER = 4'd0,
		ERR_SIGNATURE    = 4'd1,
		ERR_HEADER_SIZE  = 4'd2,
		ERR_PLANES       = 4'd3,
		ERR_BIT_COUNT    = 4'd4,
		ERR_COMPRESSED   = 4'd5,
		ERR_OFFSET       = 4'd6,
		ERR_DIMENSIONS   = 4'd7,
		ERR_TRUNC_PIXELS = 4'd8
	} err_t;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SKIP   = 5'b00010,
		PH_PIXEL  = 5'b00100,
		PH_PAD    = 5'b01000,
		PH_DRAIN  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [23:0] pixel_address;
		logic [12:0] image_width;
		logic [12:0] image_height;
		err_t        error_code;
		logic        last;
	} out_t;

endpackage

>>> design/bmp24_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_top
// Streaming decoder for uncompressed 24-bit BMP files, one file byte per
// transaction, producing header, pixel and error transactions.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel   : byte_valid / byte_stall / byte_data carry one file byte and
//                    an end-of-file flag per transaction.
//   result channel : result_valid / result_stall / result carry header-accepted,
//                    pixel (with top-row-first address) and error transactions.
//   One byte is accepted per cycle while byte_stall is low. Each byte is
//   decoded in the cycle it is accepted and its results (zero, one or two)
//   are registered into a four-entry result queue. Results leave the queue
//   one per cycle while result_stall is low. byte_stall rises while fewer
//   than two queue slots are free, so a stalled receiver backs up into the
//   byte channel after a few transactions and nothing is dropped.
//   Reset clears the queue and returns the decoder to the start of a header.
//   A byte flagged end-of-file also returns the decoder to the start of a
//   header after it is handled, so files may follow back to back.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  bmp24sd_pkg::in_t  byte_data,
	output logic              result_valid,
	input  logic              result_stall,
	output bmp24sd_pkg::out_t result
);

	// Decoder state
	bmp24sd_pkg::phase_t phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [15:0] sig_q, sig_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] info_q, info_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [15:0] planes_q, planes_d;
	logic [15:0] bitcnt_q, bitcnt_d;
	logic [31:0] compr_q, compr_d;
	logic [15:0] held_q, held_d;
	logic [1:0]  bip_q, bip_d;
	logic [12:0] col_q, col_d;
	logic [12:0] rows_q, rows_d;
	logic [1:0]  pad_q, pad_d;
	logic [23:0] row_base_q, row_base_d;

	// Result queue
	bmp24sd_pkg::out_t                   fifo_q [bmp24sd_pkg::OUT_DEPTH];
	logic [bmp24sd_pkg::OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bmp24sd_pkg::OUT_CNT_W-1:0]   cnt_q;

	logic                acc, pop;
	logic [7:0]          b;
	logic                eof;
	bmp24sd_pkg::out_t   r0, r1, first_w;
	logic                r0_v, r1_v;
	logic                do_pixel;
	logic [31:0]         h_mag32;
	logic [12:0]         w13, h13;
	logic [13:0]         rows_inc, col_inc;
	logic                fin;
	logic                hdr_ok;
	bmp24sd_pkg::err_t   hdr_code;
	logic [25:0]         base_prod;
	logic [15:0]         sig_cap;

	assign acc = byte_valid && !byte_stall;
	assign pop = result_valid && !result_stall;
	assign b   = byte_data.data_byte;
	assign eof = byte_data.end_of_file;

	// Derive image dimensions from the captured fields
	assign h_mag32   = height_q[31] ? (32'd0 - height_q) : height_q;
	assign w13       = width_q[12:0];
	assign h13       = h_mag32[12:0];
	assign rows_inc  = {1'b0, rows_q} + 14'd1;
	assign col_inc   = {1'b0, col_q} + 14'd1;
	assign fin       = (rows_inc >= {1'b0, h13}) && (col_inc >= {1'b0, w13});
	assign base_prod = (h13 - 13'd1) * w13;
	assign sig_cap   = {b, sig_q[7:0]};

	// Check header fields: size, planes, bit count, compression, offset, dimensions
	always_comb begin
		hdr_ok   = 1'b0;
		hdr_code = bmp24sd_pkg::ERR_TRUNC_HEADER;
		if (info_q != bmp24sd_pkg::INFO_SIZE) begin
			hdr_code = bmp24sd_pkg::ERR_HEADER_SIZE;
		end else if (planes_q != bmp24sd_pkg::PLANES) begin
			hdr_code = bmp24sd_pkg::ERR_PLANES;
		end else if (bitcnt_q != bmp24sd_pkg::BIT_COUNT) begin
			hdr_code = bmp24sd_pkg::ERR_BIT_COUNT;
		end else if (compr_q != 32'd0) begin
			hdr_code = bmp24sd_pkg::ERR_COMPRESSED;
		end else if (offset_q < bmp24sd_pkg::HEADER_BYTES) begin
			hdr_code = bmp24sd_pkg::ERR_OFFSET;
		end else if (width_q[31] || width_q == 32'd0 || width_q > bmp24sd_pkg::MAX_WIDTH) begin
			hdr_code = bmp24sd_pkg::ERR_DIMENSIONS;
		end else if (height_q == 32'd0 || h_mag32 > bmp24sd_pkg::MAX_HEIGHT) begin
			hdr_code = bmp24sd_pkg::ERR_DIMENSIONS;
		end else begin
			hdr_ok = 1'b1;
		end
	end

	// Decode one byte: next state and up to two results
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		sig_d      = sig_q;
		offset_d   = offset_q;
		info_d     = info_q;
		width_d    = width_q;
		height_d   = height_q;
		planes_d   = planes_q;
		bitcnt_d   = bitcnt_q;
		compr_d    = compr_q;
		held_d     = held_q;
		bip_d      = bip_q;
		col_d      = col_q;
		rows_d     = rows_q;
		pad_d      = pad_q;
		row_base_d = row_base_q;
		r0         = '0;
		r1         = '0;
		r0_v       = 1'b0;
		r1_v       = 1'b0;
		do_pixel   = 1'b0;

		unique case (phase_q)
			bmp24sd_pkg::PH_HEADER: begin
				// Capture little-endian header fields
				case (pos_q[5:0])
					6'd0:  sig_d[7:0]        = b;
					6'd1:  sig_d[15:8]       = b;
					6'd10: offset_d[7:0]     = b;
					6'd11: offset_d[15:8]    = b;
					6'd12: offset_d[23:16]   = b;
					6'd13: offset_d[31:24]   = b;
					6'd14: info_d[7:0]       = b;
					6'd15: info_d[15:8]      = b;
					6'd16: info_d[23:16]     = b;
					6'd17: info_d[31:24]     = b;
					6'd18: width_d[7:0]      = b;
					6'd19: width_d[15:8]     = b;
					6'd20: width_d[23:16]    = b;
					6'd21: width_d[31:24]    = b;
					6'd22: height_d[7:0]     = b;
					6'd23: height_d[15:8]    = b;
					6'd24: height_d[23:16]   = b;
					6'd25: height_d[31:24]   = b;
					6'd26: planes_d[7:0]     = b;
					6'd27: planes_d[15:8]    = b;
					6'd28: bitcnt_d[7:0]     = b;
					6'd29: bitcnt_d[15:8]    = b;
					6'd30: compr_d[7:0]      = b;
					6'd31: compr_d[15:8]     = b;
					6'd32: compr_d[23:16]    = b;
					6'd33: compr_d[31:24]    = b;
					default: ;
				endcase
				if (pos_q == 32'd1 && sig_cap != bmp24sd_pkg::SIGNATURE) begin
					r0_v          = 1'b1;
					r0.kind       = bmp24sd_pkg::KIND_ERROR;
					r0.error_code = bmp24sd_pkg::ERR_SIGNATURE;
					r0.last       = 1'b1;
					phase_d       = bmp24sd_pkg::PH_DRAIN;
				end else if (pos_q >= bmp24sd_pkg::LAST_HDR_POS) begin
					r0_v = 1'b1;
					if (!hdr_ok) begin
						r0.kind       = bmp24sd_pkg::KIND_ERROR;
						r0.error_code = hdr_code;
						r0.last       = 1'b1;
						phase_d       = bmp24sd_pkg::PH_DRAIN;
					end else begin
						r0.kind         = bmp24sd_pkg::KIND_HEADER;
						r0.image_width  = w13;
						r0.image_height = h13;
						phase_d         = bmp24sd_pkg::PH_SKIP;
						pos_d           = bmp24sd_pkg::HEADER_BYTES;
						row_base_d      = height_q[31] ? 24'd0 : base_prod[23:0];
					end
				end else begin
					pos_d = pos_q + 32'd1;
				end
			end
			bmp24sd_pkg::PH_SKIP: begin
				// Skip up to the pixel offset
				if (pos_q < offset_q) begin
					pos_d = pos_q + 32'd1;
				end else begin
					do_pixel = 1'b1;
				end
			end
			bmp24sd_pkg::PH_PIXEL: begin
				do_pixel = 1'b1;
			end
			bmp24sd_pkg::PH_PAD: begin
				// Drop row padding
				pad_d = pad_q - 2'd1;
				if (pad_d == 2'd0) begin
					rows_d = rows_inc[12:0];
					if (rows_inc >= {1'b0, h13}) begin
						phase_d = bmp24sd_pkg::PH_DRAIN;
					end else begin
						phase_d    = bmp24sd_pkg::PH_PIXEL;
						row_base_d = height_q[31] ? row_base_q + {11'd0, w13}
						                          : row_base_q - {11'd0, w13};
					end
				end
			end
			bmp24sd_pkg::PH_DRAIN: ;
			default: ;
		endcase

		// Gather B,G,R and emit a pixel on the third byte
		if (do_pixel) begin
			phase_d = bmp24sd_pkg::PH_PIXEL;
			case (bip_q)
				2'd0: begin
					held_d = {8'd0, b};
					bip_d  = 2'd1;
				end
				2'd1: begin
					held_d[15:8] = b;
					bip_d        = 2'd2;
				end
				default: begin
					r0_v             = 1'b1;
					r0.kind          = bmp24sd_pkg::KIND_PIXEL;
					r0.blue          = held_q[7:0];
					r0.green         = held_q[15:8];
					r0.red           = b;
					r0.pixel_address = row_base_q + {11'd0, col_q};
					r0.image_width   = w13;
					r0.image_height  = h13;
					r0.last          = fin;
					bip_d            = 2'd0;
					held_d           = 16'd0;
					if (col_inc >= {1'b0, w13}) begin
						col_d = 13'd0;
						pad_d = w13[1:0];
						if (w13[1:0] != 2'd0) begin
							phase_d = bmp24sd_pkg::PH_PAD;
						end else begin
							rows_d = rows_inc[12:0];
							if (rows_inc >= {1'b0, h13}) begin
								phase_d = bmp24sd_pkg::PH_DRAIN;
							end else begin
								row_base_d = height_q[31] ? row_base_q + {11'd0, w13}
								                          : row_base_q - {11'd0, w13};
							end
						end
					end else begin
						col_d = col_inc[12:0];
					end
				end
			endcase
		end

		// Flag an early end of file and restart for the next file
		if (eof) begin
			if (phase_d == bmp24sd_pkg::PH_HEADER) begin
				r1_v          = 1'b1;
				r1.kind       = bmp24sd_pkg::KIND_ERROR;
				r1.error_code = bmp24sd_pkg::ERR_TRUNC_HEADER;
				r1.last       = 1'b1;
			end else if (phase_d != bmp24sd_pkg::PH_DRAIN) begin
				r1_v          = 1'b1;
				r1.kind       = bmp24sd_pkg::KIND_ERROR;
				r1.error_code = bmp24sd_pkg::ERR_TRUNC_PIXELS;
				r1.last       = 1'b1;
			end
			phase_d    = bmp24sd_pkg::PH_HEADER;
			pos_d      = 32'd0;
			sig_d      = 16'd0;
			offset_d   = 32'd0;
			info_d     = 32'd0;
			width_d    = 32'd0;
			height_d   = 32'd0;
			planes_d   = 16'd0;
			bitcnt_d   = 16'd0;
			compr_d    = 32'd0;
			held_d     = 16'd0;
			bip_d      = 2'd0;
			col_d      = 13'd0;
			rows_d     = 13'd0;
			pad_d      = 2'd0;
			row_base_d = 24'd0;
		end
	end

	// Advance decoder state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bmp24sd_pkg::PH_HEADER;
			pos_q      <= '0;
			sig_q      <= '0;
			offset_q   <= '0;
			info_q     <= '0;
			width_q    <= '0;
			height_q   <= '0;
			planes_q   <= '0;
			bitcnt_q   <= '0;
			compr_q    <= '0;
			held_q     <= '0;
			bip_q      <= '0;
			col_q      <= '0;
			rows_q     <= '0;
			pad_q      <= '0;
			row_base_q <= '0;
		end else if (acc) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			sig_q      <= sig_d;
			offset_q   <= offset_d;
			info_q     <= info_d;
			width_q    <= width_d;
			height_q   <= height_d;
			planes_q   <= planes_d;
			bitcnt_q   <= bitcnt_d;
			compr_q    <= compr_d;
			held_q     <= held_d;
			bip_q      <= bip_d;
			col_q      <= col_d;
			rows_q     <= rows_d;
			pad_q      <= pad_d;
			row_base_q <= row_base_d;
		end
	end

	// Write results into the queue, first result at the write pointer
	assign first_w = r0_v ? r0 : r1;

	always_ff @(posedge clk) begin
		if (acc && (r0_v || r1_v)) begin
			fifo_q[wr_ptr_q] <= first_w;
		end
		if (acc && r0_v && r1_v) begin
			fifo_q[wr_ptr_q + 1'b1] <= r1;
		end
	end

	// Track queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (acc ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0);
			rd_ptr_q <= rd_ptr_q + {{(bmp24sd_pkg::OUT_PTR_W-1){1'b0}}, pop};
			cnt_q    <= cnt_q
			            + (acc ? ({2'b0, r0_v} + {2'b0, r1_v}) : 3'd0)
			            - {{(bmp24sd_pkg::OUT_CNT_W-1){1'b0}}, pop};
		end
	end

	// Hold off bytes while fewer than two slots are free
	assign byte_stall   = cnt_q > 3'(bmp24sd_pkg::OUT_DEPTH - 2);
	assign result_valid = cnt_q != '0;
	assign result       = fifo_q[rd_ptr_q];

endmodule
